FILE: src/elgr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgr_pkg
// Shared types and constants of the elevation grid resampler.
// ----------------------------------------------------------------------------
package elgr_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int IDX_W       = 10;
   localparam int DIM_RAW_W   = 8;
   localparam int OUT_RAW_W   = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;
   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int SUM_W       = SAMPLE_W + 2;
   localparam int AVG_SHIFT   = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_SIZE   = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_COL,
      ST_ROW_START,
      ST_DIV_ROW,
      ST_BASE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_RD_D,
      ST_ACC,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      RD_BASE,
      RD_RIGHT,
      RD_DOWN,
      RD_DIAG
   } rd_sel_type;

   typedef struct packed {
      logic       load_write;
      logic       capture;
      logic       start_row;
      logic       div_step;
      logic       save_col;
      logic       save_row;
      logic       calc_base;
      rd_sel_type rd_sel;
      logic       acc_clear;
      logic       acc_add;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic div_last;
      logic out_free;
   } sts_type;

endpackage

FILE: src/elgr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgr_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module elgr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/elgr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgr_ctrl
// Sequencer: accepts transactions, steps the divider, the reads and the result.
// ----------------------------------------------------------------------------
module elgr_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_operation,
   output logic              req_tready,
   input  elgr_pkg::sts_type sts,
   output elgr_pkg::cmd_type cmd
);
   import elgr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_BASE;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_operation == OP_LOAD) begin
                  cmd.load_write = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  state_in    = sts.in_range ? ST_DIV_COL : ST_RESULT;
               end
            end
         end
         ST_DIV_COL: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.save_col = 1'b1;
               state_in     = ST_ROW_START;
            end
         end
         ST_ROW_START: begin
            cmd.start_row = 1'b1;
            state_in      = ST_DIV_ROW;
         end
         ST_DIV_ROW: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.save_row = 1'b1;
               state_in     = ST_BASE;
            end
         end
         ST_BASE: begin
            cmd.calc_base = 1'b1;
            state_in      = ST_RD_A;
         end
         ST_RD_A: begin
            cmd.rd_sel = RD_BASE;
            state_in   = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.rd_sel    = RD_RIGHT;
            cmd.acc_clear = 1'b1;
            state_in      = ST_RD_C;
         end
         ST_RD_C: begin
            cmd.rd_sel  = RD_DOWN;
            cmd.acc_add = 1'b1;
            state_in    = ST_RD_D;
         end
         ST_RD_D: begin
            cmd.rd_sel  = RD_DIAG;
            cmd.acc_add = 1'b1;
            state_in    = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc_add = 1'b1;
            state_in    = ST_RESULT;
         end
         ST_RESULT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_query_starts_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_tvalid && req_operation == OP_QUERY && sts.in_range)
      |=> state_ff == ST_DIV_COL)
      else $error("in-range query did not start the column division");

   a_result_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESULT && sts.out_free) |=> state_ff == ST_IDLE)
      else $error("delivered result did not return to idle");
`endif

endmodule

FILE: src/elgr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elgr_datapath
// Configuration, load pointer, serial divider, neighbourhood reads and result.
// ----------------------------------------------------------------------------
module elgr_datapath #(
   parameter int MAX_SRC_DIM = 256,
   parameter int MAX_OUT_DIM = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  elgr_pkg::cmd_type                  cmd,
   output elgr_pkg::sts_type                  sts,
   input  logic                               csr_we,
   input  logic [elgr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [elgr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [elgr_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                               req_first,
   input  logic [elgr_pkg::IDX_W-1:0]         req_col,
   input  logic [elgr_pkg::IDX_W-1:0]         req_row,
   input  logic                               rsp_tready,
   output logic                               rsp_tvalid,
   output logic [elgr_pkg::SAMPLE_W-1:0]      rsp_pixel,
   output logic                               rsp_oor
);
   import elgr_pkg::*;

   localparam int DIMW = $clog2(MAX_SRC_DIM + 1);
   localparam int QW   = $clog2(MAX_SRC_DIM);
   localparam int CW   = (QW > 1) ? $clog2(QW) : 1;
   localparam int NW   = $clog2(MAX_OUT_DIM + 1);
   localparam int SW   = NW + QW;
   localparam int PW   = IDX_W + DIMW;
   localparam int MW   = QW + DIMW;
   localparam int DRW  = (DIMW > DIM_RAW_W) ? DIMW : DIM_RAW_W;
   localparam int NRW  = (NW > OUT_RAW_W) ? NW : OUT_RAW_W;
   localparam int CMPW = (NW > IDX_W) ? NW : IDX_W;

   // configuration
   logic [DIM_RAW_W-1:0] width_ff;
   logic [DIM_RAW_W-1:0] height_ff;
   logic [OUT_RAW_W-1:0] size_ff;
   logic [DIMW-1:0]      w_eff;
   logic [DIMW-1:0]      h_eff;
   logic [NW-1:0]        n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RAW_W'(1);
         height_ff <= DIM_RAW_W'(1);
         size_ff   <= OUT_RAW_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            REG_SRC_WIDTH:  width_ff  <= csr_wdata[DIM_RAW_W-1:0];
            REG_SRC_HEIGHT: height_ff <= csr_wdata[DIM_RAW_W-1:0];
            REG_OUT_SIZE:   size_ff   <= csr_wdata[OUT_RAW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   function automatic logic [DIMW-1:0] eff_dim(input logic [DIM_RAW_W-1:0] raw);
      logic [DRW-1:0] ext;
      ext = DRW'(raw);
      if (ext == '0) begin
         return DIMW'(1);
      end else if (ext > DRW'(MAX_SRC_DIM)) begin
         return DIMW'(MAX_SRC_DIM);
      end else begin
         return DIMW'(ext);
      end
   endfunction

   always_comb begin
      logic [NRW-1:0] n_ext;
      n_ext = NRW'(size_ff);
      w_eff = eff_dim(width_ff);
      h_eff = eff_dim(height_ff);
      n_eff = (n_ext > NRW'(MAX_OUT_DIM)) ? NW'(MAX_OUT_DIM) : NW'(n_ext);
   end

   assign sts.in_range = (n_eff != '0) && (CMPW'(req_col) < CMPW'(n_eff))
                         && (CMPW'(req_row) < CMPW'(n_eff));

   // load pointer and store
   logic [STORE_AW-1:0] ptr_ff;
   logic [STORE_AW-1:0] wr_addr;
   logic [STORE_AW-1:0] rd_addr;
   logic [SAMPLE_W-1:0] rd_data;

   assign wr_addr = req_first ? '0 : ptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (cmd.load_write) begin
         ptr_ff <= wr_addr + STORE_AW'(1);
      end
   end

   elgr_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load_write),
      .wr_addr (wr_addr),
      .wr_data (req_sample),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // serial restoring divider, one quotient bit a cycle
   logic [IDX_W-1:0] row_idx_ff;
   logic             oor_ff;
   logic [SW-1:0]    rem_ff;
   logic [SW-1:0]    dvs_ff;
   logic [QW-1:0]    q_ff;
   logic [CW-1:0]    cnt_ff;
   logic             sub_ok;
   logic [SW-1:0]    rem_step;
   logic [QW-1:0]    q_in;
   logic [SW-1:0]    dvs_init;
   logic [PW-1:0]    col_prod;
   logic [PW-1:0]    row_prod;

   assign sub_ok   = rem_ff >= dvs_ff;
   assign rem_step = sub_ok ? rem_ff - dvs_ff : rem_ff;
   assign q_in     = QW'({q_ff, sub_ok});
   assign dvs_init = SW'(n_eff) << (QW - 1);
   assign col_prod = PW'(req_col) * PW'(w_eff);
   assign row_prod = PW'(row_idx_ff) * PW'(h_eff);
   assign sts.div_last = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_idx_ff <= req_row;
         oor_ff     <= !sts.in_range;
         rem_ff     <= SW'(col_prod);
         dvs_ff     <= dvs_init;
         cnt_ff     <= CW'(QW - 1);
      end else if (cmd.start_row) begin
         rem_ff <= SW'(row_prod);
         dvs_ff <= dvs_init;
         cnt_ff <= CW'(QW - 1);
      end else if (cmd.div_step) begin
         rem_ff <= rem_step;
         dvs_ff <= dvs_ff >> 1;
         q_ff   <= q_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
   end

   // base address and edge flags
   logic [QW-1:0]       col_ff;
   logic [QW-1:0]       row_ff;
   logic [STORE_AW-1:0] base_ff;
   logic                right_ff;
   logic                down_ff;
   logic [MW-1:0]       row_off;
   logic [STORE_AW-1:0] w_addr;

   assign row_off = MW'(row_ff) * MW'(w_eff);
   assign w_addr  = STORE_AW'(w_eff);

   always_ff @(posedge clock) begin
      if (cmd.save_col) begin
         col_ff <= q_in;
      end
      if (cmd.save_row) begin
         row_ff <= q_in;
      end
      if (cmd.calc_base) begin
         base_ff  <= STORE_AW'(row_off) + STORE_AW'(col_ff);
         right_ff <= (DIMW'(col_ff) + DIMW'(1)) < w_eff;
         down_ff  <= (DIMW'(row_ff) + DIMW'(1)) < h_eff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_BASE:  rd_addr = base_ff;
         RD_RIGHT: rd_addr = right_ff ? base_ff + STORE_AW'(1) : base_ff;
         RD_DOWN:  rd_addr = down_ff ? base_ff + w_addr : base_ff;
         RD_DIAG:  rd_addr = (right_ff && down_ff) ? base_ff + w_addr + STORE_AW'(1)
                                                   : base_ff;
         default:  rd_addr = base_ff;
      endcase
   end

   // neighbourhood sum
   logic [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (cmd.acc_clear) begin
         sum_ff <= SUM_W'(rd_data);
      end else if (cmd.acc_add) begin
         sum_ff <= sum_ff + SUM_W'(rd_data);
      end
   end

   // output register
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] pixel_ff;
   logic                rsp_oor_ff;

   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pixel_ff   <= oor_ff ? '0 : SAMPLE_W'(sum_ff >> AVG_SHIFT);
         rsp_oor_ff <= oor_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_pixel  = pixel_ff;
   assign rsp_oor    = rsp_oor_ff;

`ifndef ASSERT_OFF
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("result loaded over one not yet taken");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_oor_ff) |-> pixel_ff == '0)
      else $error("out-of-range result carries a non-zero pixel");
`endif

endmodule

FILE: src/elevation_grid_resample_core.sv
`timescale 1ns / 1ps
// Queries: an in-range query maps its column, then its row, through the bit-serial
// divider, then makes four reads through the single store read port; an out-of-range
// query goes straight to its result. No request is taken until that result is loaded.
// Loads: one per cycle while no query is in progress. Reset (synchronous): clears
// sequencer, response valid and load pointer, sets the registers to 1; the store is
// not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// elevation_grid_resample_core
// Nearest-position resampler of an elevation grid with 2x2 box average.
// ----------------------------------------------------------------------------
module elevation_grid_resample_core #(
   parameter int MAX_SRC_DIM = 256,
   parameter int MAX_OUT_DIM = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: sample[15:0], first_sample[16], out_col[26:17], out_row[36:27], zero[39:37]
   input  logic [elgr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: operation[0]
   input  logic                                req_tuser,
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // tdata: pixel[15:0]
   output logic [elgr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // tuser: out_of_range[0]
   output logic                                rsp_tuser,
   // configuration write port
   input  logic                                csr_we,
   input  logic [elgr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [elgr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import elgr_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // unpack the request transaction
   logic [SAMPLE_W-1:0] req_sample;
   logic                req_first;
   logic [IDX_W-1:0]    req_col;
   logic [IDX_W-1:0]    req_row;

   assign req_sample = req_tdata[SAMPLE_W-1:0];
   assign req_first  = req_tdata[SAMPLE_W];
   assign req_col    = req_tdata[SAMPLE_W+IDX_W:SAMPLE_W+1];
   assign req_row    = req_tdata[SAMPLE_W+2*IDX_W:SAMPLE_W+IDX_W+1];

   // sequencer: takes a transaction only when idle, loads return to idle at once
   elgr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_operation (req_tuser),
      .req_tready    (req_tready),
      .sts           (sts),
      .cmd           (cmd)
   );

   // datapath: registers, store, divider, reads and the output register that
   // holds a finished result while the next transaction is accepted
   elgr_datapath #(
      .MAX_SRC_DIM (MAX_SRC_DIM),
      .MAX_OUT_DIM (MAX_OUT_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_sample (req_sample),
      .req_first  (req_first),
      .req_col    (req_col),
      .req_row    (req_row),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_pixel  (rsp_tdata),
      .rsp_oor    (rsp_tuser)
   );

endmodule
